[hw/rtl/fdt_pkg.sv]
package fdt_pkg;

   localparam int TEMP_W     = 13;
   localparam int DUTY_W     = 10;
   localparam int PCT_W      = 7;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 60;
   localparam int CURVE_PTS  = 6;
   localparam int SEG_IDX_W  = 3;
   localparam int OP_A_W     = 16;
   localparam int OP_B_W     = DUTY_W;
   localparam int NUM_W      = OP_A_W + OP_B_W;
   localparam int DIV_W      = 16;
   localparam int DIV_STEPS  = NUM_W;
   localparam int COUNT_W    = $clog2(DIV_STEPS);

   // duty / 10 as (duty * 205) >> 11, exact for duty below 1029
   localparam int PCT_MUL_W  = 8;
   localparam int PCT_SHIFT  = 11;
   localparam logic [PCT_MUL_W-1:0] PCT_MUL = 8'd205;

   typedef enum logic [1:0] {
      MODE_AUTO    = 2'd0,
      MODE_TEMP    = 2'd1,
      MODE_RPM     = 2'd2,
      MODE_INVALID = 2'd3
   } fdt_mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CLAMPED  = 2'd1,
      STATUS_BAD_MODE = 2'd2
   } fdt_status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE         = 3'd0,
      CSR_TARGET_TEMP  = 3'd1,
      CSR_TARGET_SPEED = 3'd2,
      CSR_MAX_SPEED    = 3'd3,
      CSR_TEMP_SPAN    = 3'd4,
      CSR_HYST_BAND    = 3'd5,
      CSR_CURVE_TEMPS  = 3'd6,
      CSR_CURVE_DUTIES = 3'd7
   } fdt_csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'd0,
      ST_PREP = 3'd1,
      ST_MUL  = 3'd2,
      ST_DIV  = 3'd3,
      ST_FIN  = 3'd4
   } fdt_state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic mul;
      logic step;
      logic fin;
   } fdt_cmd_type;

endpackage

[hw/rtl/fdt_req_if.sv]
interface fdt_req_if;
   import fdt_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] current_temp;
   logic signed [TEMP_W-1:0] room_temp;
   logic                     room_temp_valid;

   modport source (output valid, current_temp, room_temp, room_temp_valid, input ready);
   modport sink   (input valid, current_temp, room_temp, room_temp_valid, output ready);
endinterface

[hw/rtl/fdt_rsp_if.sv]
interface fdt_rsp_if;
   import fdt_pkg::*;

   logic                valid;
   logic                ready;
   logic [DUTY_W-1:0]   duty;
   logic [PCT_W-1:0]    duty_percent;
   logic [STATUS_W-1:0] status;

   modport source (output valid, duty, duty_percent, status, input ready);
   modport sink   (input valid, duty, duty_percent, status, output ready);
endinterface

[hw/rtl/fdt_csr_if.sv]
interface fdt_csr_if;
   import fdt_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/fdt_ctrl.sv]
module fdt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fdt_pkg::fdt_cmd_type cmd
);
   import fdt_pkg::*;

   fdt_state_type      state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               out_valid_ff, out_valid_in;
   logic               last_step;

   assign last_step = (count_ff == COUNT_W'(DIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: state_in = ST_MUL;
         ST_MUL:  state_in = ST_DIV;
         ST_DIV: begin
            if (last_step) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!out_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      count_in  = count_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_PREP: cmd.prep = 1'b1;
         ST_MUL: begin
            cmd.mul  = 1'b1;
            count_in = '0;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            count_in = count_ff + COUNT_W'(1);
         end
         ST_FIN: cmd.fin = !out_valid_ff || rsp_ready;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ready) out_valid_in = 1'b0;
      if (cmd.fin)   out_valid_in = 1'b1;
   end

   assign rsp_valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.prep, cmd.mul, cmd.step, cmd.fin}))
      else $error("more than one datapath command at once");

   a_load_then_prep: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.prep)
      else $error("operand setup did not follow a transaction");

   a_mul_then_step: assert property (@(posedge clock) disable iff (reset)
      cmd.mul |=> (cmd.step && count_ff == '0))
      else $error("divider did not start from step zero");

   a_fin_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.fin |=> rsp_valid)
      else $error("result not presented after finish");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !(cmd.prep || cmd.mul || cmd.step))
      else $error("ready while an item is in work");

endmodule

[hw/rtl/fdt_dp.sv]
module fdt_dp #(
   parameter int MIN_DUTY = 0,
   parameter int MAX_DUTY = 1000
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fdt_pkg::fdt_cmd_type                 cmd,
   input  logic                                 csr_write,
   input  logic [fdt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [fdt_pkg::CSR_DATA_W-1:0]       csr_data,
   input  logic signed [fdt_pkg::TEMP_W-1:0]    current_temp,
   input  logic signed [fdt_pkg::TEMP_W-1:0]    room_temp,
   input  logic                                 room_temp_valid,
   output logic [fdt_pkg::DUTY_W-1:0]           duty,
   output logic [fdt_pkg::PCT_W-1:0]            duty_percent,
   output logic [fdt_pkg::STATUS_W-1:0]         status
);
   import fdt_pkg::*;

   localparam int RAW_W = NUM_W + 2;
   localparam logic signed [RAW_W-1:0] MaxRaw = RAW_W'(MAX_DUTY);
   localparam logic signed [RAW_W-1:0] MinRaw = RAW_W'(MIN_DUTY);
   localparam logic [OP_B_W-1:0]       MaxDutyOp = OP_B_W'(MAX_DUTY);

   // configuration registers
   fdt_mode_type          mode_ff;
   logic signed [7:0]     target_temp_ff;
   logic [15:0]           target_speed_ff;
   logic [15:0]           max_speed_ff;
   logic [11:0]           temp_span_ff;
   logic [7:0]            hyst_band_ff;
   logic [8*CURVE_PTS-1:0]      curve_temps_ff;
   logic [DUTY_W*CURVE_PTS-1:0] curve_duties_ff;
   logic                  hyst_low_side_ff, hyst_low_side_in;

   // item and operand registers
   logic signed [TEMP_W-1:0] cur_ff, room_ff;
   logic                     room_ok_ff;
   logic [OP_A_W-1:0]        op_a_ff, op_a_in;
   logic [OP_B_W-1:0]        op_b_ff, op_b_in;
   logic [DIV_W-1:0]         div_ff, div_in;
   logic [DUTY_W-1:0]        base_ff, base_in;
   logic                     neg_ff, neg_in;
   logic                     bad_ff, bad_in;
   fdt_status_type           status_item_ff, status_item_in;
   logic [NUM_W-1:0]         quo_ff;
   logic [DIV_W-1:0]         rem_ff;
   logic [DUTY_W-1:0]        duty_ff, duty_in;
   logic [PCT_W-1:0]         pct_ff, pct_in;
   logic [STATUS_W-1:0]      status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_AUTO;
         target_temp_ff   <= 8'sd40;
         target_speed_ff  <= 16'd0;
         max_speed_ff     <= 16'd3000;
         temp_span_ff     <= 12'd320;
         hyst_band_ff     <= 8'd5;
         curve_temps_ff   <= 48'h46_3C_32_28_1E_14;
         curve_duties_ff  <= '0;
      end else if (csr_write) begin
         case (fdt_csr_index_type'(csr_index))
            CSR_MODE:         mode_ff         <= fdt_mode_type'(csr_data[1:0]);
            CSR_TARGET_TEMP:  target_temp_ff  <= csr_data[7:0];
            CSR_TARGET_SPEED: target_speed_ff <= csr_data[15:0];
            CSR_MAX_SPEED:    max_speed_ff    <= csr_data[15:0];
            CSR_TEMP_SPAN:    temp_span_ff    <= csr_data[11:0];
            CSR_HYST_BAND:    hyst_band_ff    <= csr_data[7:0];
            CSR_CURVE_TEMPS:  curve_temps_ff  <= csr_data[8*CURVE_PTS-1:0];
            CSR_CURVE_DUTIES: curve_duties_ff <= csr_data[DUTY_W*CURVE_PTS-1:0];
            default:          mode_ff         <= mode_ff;
         endcase
      end
   end

   // operand setup
   logic signed [13:0] cur14, room14, target16, t_lo, t_hi, hyst_t;
   logic signed [13:0] hyst_diff, hyst_abs, hyst_excess, room_excess, excess;
   logic [OP_A_W-1:0]  prop_a;
   logic [DIV_W-1:0]   span_div;
   logic               speed_clamp;
   logic [15:0]        speed;
   logic [CURVE_PTS-1:0] above;
   logic               seg_found;
   logic [SEG_IDX_W-1:0] seg_lo, seg_hi;
   logic [7:0]         ct_lo, ct_hi;
   logic [DUTY_W-1:0]  cd_lo, cd_hi;
   logic signed [12:0] seg_w;
   logic signed [13:0] seg_off;
   logic signed [10:0] seg_dd;

   always_comb begin
      cur14       = 14'(cur_ff);
      room14      = 14'(room_ff);
      target16    = 14'($signed({target_temp_ff, 4'b0}));
      t_lo        = target16 - 14'sd16;
      t_hi        = target16 + 14'sd16;
      hyst_t      = hyst_low_side_ff ? t_lo : t_hi;
      hyst_diff   = hyst_t - cur14;
      hyst_abs    = hyst_diff[13] ? -hyst_diff : hyst_diff;
      hyst_excess = cur14 - hyst_t;
      room_excess = cur14 - room14;
      excess      = (mode_ff == MODE_AUTO) ? room_excess : hyst_excess;
      prop_a      = (excess > 14'sd0) ? OP_A_W'(excess[12:0]) : '0;
      span_div    = (temp_span_ff == '0) ? DIV_W'(1) : DIV_W'(temp_span_ff);

      speed_clamp = target_speed_ff > max_speed_ff;
      speed       = speed_clamp ? max_speed_ff : target_speed_ff;

      for (int i = 0; i < CURVE_PTS; i++) begin
         above[i] = cur14 > $signed({2'b0, curve_temps_ff[8*i +: 8], 4'b0});
      end
      seg_found = 1'b0;
      seg_lo    = '0;
      for (int i = 0; i < CURVE_PTS - 1; i++) begin
         if (above[i]) begin
            seg_found = 1'b1;
            seg_lo    = SEG_IDX_W'(i);
         end
      end
      seg_hi  = seg_lo + SEG_IDX_W'(1);
      ct_lo   = curve_temps_ff[8*seg_lo +: 8];
      ct_hi   = curve_temps_ff[8*seg_hi +: 8];
      cd_lo   = curve_duties_ff[DUTY_W*seg_lo +: DUTY_W];
      cd_hi   = curve_duties_ff[DUTY_W*seg_hi +: DUTY_W];
      seg_w   = $signed({1'b0, ct_hi, 4'b0}) - $signed({1'b0, ct_lo, 4'b0});
      seg_off = cur14 - $signed({2'b0, ct_lo, 4'b0});
      seg_dd  = $signed({1'b0, cd_hi}) - $signed({1'b0, cd_lo});
   end

   always_comb begin
      op_a_in        = '0;
      op_b_in        = MaxDutyOp;
      div_in         = DIV_W'(1);
      base_in        = '0;
      neg_in         = 1'b0;
      bad_in         = 1'b0;
      status_item_in = STATUS_OK;
      case (mode_ff)
         MODE_AUTO: begin
            if (room_ok_ff) begin
               op_a_in = prop_a;
               div_in  = span_div;
            end else if (above[CURVE_PTS-1]) begin
               base_in = curve_duties_ff[DUTY_W*(CURVE_PTS-1) +: DUTY_W];
            end else if (!seg_found) begin
               base_in = curve_duties_ff[DUTY_W-1:0];
            end else begin
               base_in = cd_lo;
               if (seg_w > 13'sd0) begin
                  op_a_in = OP_A_W'(seg_off[11:0]);
                  op_b_in = seg_dd[10] ? OP_B_W'(-seg_dd) : OP_B_W'(seg_dd);
                  neg_in  = seg_dd[10];
                  div_in  = DIV_W'(seg_w[11:0]);
               end
            end
         end
         MODE_TEMP: begin
            op_a_in = prop_a;
            div_in  = span_div;
         end
         MODE_RPM: begin
            if (speed_clamp) status_item_in = STATUS_CLAMPED;
            if (max_speed_ff != '0) begin
               op_a_in = speed;
               div_in  = max_speed_ff;
            end
         end
         MODE_INVALID: begin
            bad_in         = 1'b1;
            status_item_in = STATUS_BAD_MODE;
         end
         default: bad_in = 1'b1;
      endcase
   end

   always_comb begin
      hyst_low_side_in = hyst_low_side_ff;
      if (cmd.prep && mode_ff == MODE_TEMP) begin
         if (hyst_low_side_ff) begin
            if (hyst_abs < $signed({6'b0, hyst_band_ff})) hyst_low_side_in = 1'b0;
         end else if (cur14 > t_hi) begin
            hyst_low_side_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hyst_low_side_ff <= 1'b1;
      end else begin
         hyst_low_side_ff <= hyst_low_side_in;
      end
   end

   // restoring divider, one quotient bit per step
   logic [DIV_W:0] trial;
   logic           fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, div_ff};

   // finish: base plus signed quotient, clamp (zero for a bad mode), whole percent
   logic signed [RAW_W-1:0]      raw;
   logic [DUTY_W+PCT_MUL_W-1:0]  pct_prod;

   always_comb begin
      raw = neg_ff ? ($signed(RAW_W'(base_ff)) - $signed(RAW_W'(quo_ff)))
                   : ($signed(RAW_W'(base_ff)) + $signed(RAW_W'(quo_ff)));
      if (raw > MaxRaw)      duty_in = DUTY_W'(MAX_DUTY);
      else if (raw < MinRaw) duty_in = DUTY_W'(MIN_DUTY);
      else                   duty_in = raw[DUTY_W-1:0];
      if (bad_ff) duty_in = '0;
      pct_prod = duty_in * PCT_MUL;
      pct_in   = pct_prod[PCT_SHIFT +: PCT_W];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff     <= current_temp;
         room_ff    <= room_temp;
         room_ok_ff <= room_temp_valid;
      end
      if (cmd.prep) begin
         op_a_ff        <= op_a_in;
         op_b_ff        <= op_b_in;
         div_ff         <= div_in;
         base_ff        <= base_in;
         neg_ff         <= neg_in;
         bad_ff         <= bad_in;
         status_item_ff <= status_item_in;
      end
      if (cmd.mul) begin
         quo_ff <= op_a_ff * op_b_ff;
         rem_ff <= '0;
      end else if (cmd.step) begin
         rem_ff <= fits ? DIV_W'(trial - {1'b0, div_ff}) : trial[DIV_W-1:0];
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
      end
      if (cmd.fin) begin
         duty_ff   <= duty_in;
         pct_ff    <= pct_in;
         status_ff <= status_item_ff;
      end
   end

   assign duty         = duty_ff;
   assign duty_percent = pct_ff;
   assign status       = status_ff;

endmodule

[hw/rtl/fan_duty_from_temperature_core.sv]
// rsp.valid is set for a result after the req transaction has passed setup, multiply,
// 26 divider steps and finish; finish waits while an earlier result is not yet taken
// req.ready is high only in idle, so with the bit-serial divider a new item waits until the last one finishes
// reset: synchronous active high; configuration registers return to defaults,
// hysteresis flag set and no result pending; csr.ready is always high
module fan_duty_from_temperature_core #(
   parameter int MIN_DUTY = 0,
   parameter int MAX_DUTY = 1000
) (
   input logic       clock,
   input logic       reset,
   fdt_req_if.sink   req,
   fdt_rsp_if.source rsp,
   fdt_csr_if.sink   csr
);
   import fdt_pkg::*;

   fdt_cmd_type cmd;

   assign csr.ready = 1'b1;

   fdt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   fdt_dp #(
      .MIN_DUTY (MIN_DUTY),
      .MAX_DUTY (MAX_DUTY)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_write       (csr.valid),
      .csr_index       (csr.index),
      .csr_data        (csr.data),
      .current_temp    (req.current_temp),
      .room_temp       (req.room_temp),
      .room_temp_valid (req.room_temp_valid),
      .duty            (rsp.duty),
      .duty_percent    (rsp.duty_percent),
      .status          (rsp.status)
   );

endmodule

[verif/tb_fan_duty_from_temperature_core.sv]
`timescale 1ns / 100ps

module tb_fan_duty_from_temperature_core;
   import fdt_pkg::*;

   localparam int DUTY_MIN        = 0;
   localparam int DUTY_MAX        = 1000;
   localparam int RANDOM_PHASES   = 26;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 1_000_000;

   typedef struct {
      logic signed [TEMP_W-1:0] cur;
      logic signed [TEMP_W-1:0] room;
      logic                     room_ok;
   } temp_sample_type;

   typedef struct {
      logic [DUTY_W-1:0] duty;
      logic [PCT_W-1:0]  pct;
      fdt_status_type    status;
   } fan_duty_type;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_LONG
   } stall_style_type;

   logic clock = 1'b0;
   logic reset;

   fdt_req_if req_ch ();
   fdt_rsp_if rsp_ch ();
   fdt_csr_if csr_ch ();

   fan_duty_from_temperature_core #(
      .MIN_DUTY(DUTY_MIN),
      .MAX_DUTY(DUTY_MAX)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   always #5 clock = ~clock;

   // predictor copy of the registers and the hysteresis flag
   fdt_mode_type             cfg_mode;
   logic signed [7:0]        cfg_target_temp;
   logic [15:0]              cfg_target_speed;
   logic [15:0]              cfg_max_speed;
   logic [11:0]              cfg_temp_span;
   logic [7:0]               cfg_hyst_band;
   logic [47:0]              cfg_curve_temps;
   logic [59:0]              cfg_curve_duties;
   logic                     low_side;

   temp_sample_type pending_samples[$];
   fan_duty_type    expected_duties[$];
   temp_sample_type offered;

   int n_queued   = 0;
   int n_sent     = 0;
   int n_checked  = 0;
   int n_errors   = 0;
   int n_settings = 0;
   int cycle_count = 0;

   int              burst_max   = 1;
   int              gap_max     = 0;
   int              burst_left  = 0;
   int              gap_left    = 0;
   stall_style_type stall_style = STALL_NONE;
   int              stall_left  = 0;

   function automatic longint knot_temp(input int i);
      return longint'(cfg_curve_temps[8*i +: 8]) * 16;
   endfunction

   function automatic longint knot_duty(input int i);
      return longint'(cfg_curve_duties[10*i +: 10]);
   endfunction

   function automatic longint excess_duty(input longint excess);
      longint span;
      span = (cfg_temp_span == 0) ? 1 : longint'(cfg_temp_span);
      if (excess <= 0) return 0;
      return excess * DUTY_MAX / span;
   endfunction

   function automatic longint curve_duty(input longint cur);
      longint lo_t;
      longint width;
      if (cur > knot_temp(5)) return knot_duty(5);
      for (int i = 5; i > 0; i--) begin
         lo_t = knot_temp(i - 1);
         if (cur > lo_t) begin
            width = knot_temp(i) - lo_t;
            if (width <= 0) return knot_duty(i - 1);
            return knot_duty(i - 1) + (cur - lo_t) * (knot_duty(i) - knot_duty(i - 1)) / width;
         end
      end
      return knot_duty(0);
   endfunction

   // advances the hysteresis flag as a side effect
   function automatic fan_duty_type predict_duty(input temp_sample_type s);
      fan_duty_type r;
      longint       cur;
      longint       room;
      longint       thr;
      longint       distance;
      longint       d;
      longint       spd;
      longint       top;
      cur = s.cur;
      room = s.room;
      d = 0;
      r.status = STATUS_OK;
      case (cfg_mode)
         MODE_INVALID: begin
            r.duty = '0;
            r.pct = '0;
            r.status = STATUS_BAD_MODE;
            return r;
         end
         MODE_AUTO: begin
            d = s.room_ok ? excess_duty(cur - room) : curve_duty(cur);
         end
         MODE_TEMP: begin
            if (low_side) begin
               thr = longint'(cfg_target_temp) * 16 - 16;
               distance = (thr > cur) ? thr - cur : cur - thr;
               if (distance < longint'(cfg_hyst_band)) low_side = 1'b0;
            end else begin
               thr = longint'(cfg_target_temp) * 16 + 16;
               if (cur > thr) low_side = 1'b1;
            end
            d = excess_duty(cur - thr);
         end
         MODE_RPM: begin
            spd = longint'(cfg_target_speed);
            top = longint'(cfg_max_speed);
            if (spd > top) begin
               spd = top;
               r.status = STATUS_CLAMPED;
            end
            d = (top == 0) ? 0 : spd * DUTY_MAX / top;
         end
         default: d = 0;
      endcase
      if (d > DUTY_MAX) d = DUTY_MAX;
      if (d < DUTY_MIN) d = DUTY_MIN;
      r.duty = d[DUTY_W-1:0];
      r.pct = PCT_W'(d / 10);
      return r;
   endfunction

   function automatic logic signed [TEMP_W-1:0] to_temp(input longint v);
      if (v > 4095) v = 4095;
      if (v < -4096) v = -4096;
      return v[TEMP_W-1:0];
   endfunction

   function automatic temp_sample_type random_sample();
      temp_sample_type s;
      longint          centre;
      int              spread;
      s.room_ok = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) begin
         s.cur = TEMP_W'($urandom_range(0, 8191));
         s.room = TEMP_W'($urandom_range(0, 8191));
         return s;
      end
      spread = 48;
      case (cfg_mode)
         MODE_AUTO: begin
            centre = s.room_ok ? longint'($urandom_range(0, 8191)) - 4096
                               : knot_temp($urandom_range(0, 5));
         end
         MODE_TEMP: begin
            centre = longint'(cfg_target_temp) * 16 + ($urandom_range(0, 1) ? 16 : -16);
            spread = int'(cfg_hyst_band) + 24;
         end
         default: begin
            centre = longint'($urandom_range(0, 8191)) - 4096;
         end
      endcase
      s.cur = to_temp(centre + longint'($urandom_range(0, 2 * spread)) - spread);
      s.room = to_temp(longint'(s.cur) + 32
                       - longint'($urandom_range(0, 2 * int'(cfg_temp_span) + 64)));
      return s;
   endfunction

   task automatic write_reg(input fdt_csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      case (idx)
         CSR_MODE:         cfg_mode = fdt_mode_type'(value[1:0]);
         CSR_TARGET_TEMP:  cfg_target_temp = value[7:0];
         CSR_TARGET_SPEED: cfg_target_speed = value[15:0];
         CSR_MAX_SPEED:    cfg_max_speed = value[15:0];
         CSR_TEMP_SPAN:    cfg_temp_span = value[11:0];
         CSR_HYST_BAND:    cfg_hyst_band = value[7:0];
         CSR_CURVE_TEMPS:  cfg_curve_temps = value[47:0];
         CSR_CURVE_DUTIES: cfg_curve_duties = value[59:0];
         default:          cfg_mode = cfg_mode;
      endcase
   endtask

   task automatic queue_sample(input longint cur, input longint room, input bit ok);
      temp_sample_type s;
      s.cur = to_temp(cur);
      s.room = to_temp(room);
      s.room_ok = ok;
      pending_samples.push_back(s);
      n_queued++;
   endtask

   task automatic wait_results();
      while (n_checked != n_queued) @(posedge clock);
   endtask

   task automatic random_settings(input fdt_mode_type m);
      logic [7:0]  target8;
      logic [15:0] top;
      logic [15:0] spd;
      logic [11:0] span;
      logic [7:0]  band;
      logic [47:0] temps;
      logic [59:0] duties;
      int          t;
      case ($urandom_range(0, 5))
         0:       target8 = 8'd125;
         1:       target8 = 8'hd8;  // -40
         2:       target8 = 8'h80;
         3:       target8 = 8'h7f;
         default: target8 = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 9))
         0:       top = 16'd0;
         1:       top = 16'd1;
         2:       top = 16'hffff;
         default: top = 16'($urandom_range(1, 6000));
      endcase
      case ($urandom_range(0, 5))
         0:       spd = 16'd0;
         1:       spd = 16'hffff;
         2:       spd = top;
         default: spd = 16'($urandom_range(0, 6000));
      endcase
      case ($urandom_range(0, 7))
         0:       span = 12'd0;
         1:       span = 12'd1;
         2:       span = 12'hfff;
         default: span = 12'($urandom_range(1, 600));
      endcase
      case ($urandom_range(0, 5))
         0:       band = 8'd0;
         1:       band = 8'hff;
         default: band = 8'($urandom_range(0, 40));
      endcase
      if ($urandom_range(0, 4) == 0) begin
         temps = 48'({$urandom(), $urandom()});
      end else begin
         t = $urandom_range(0, 80);
         for (int i = 0; i < CURVE_PTS; i++) begin
            temps[8*i +: 8] = 8'(t);
            t = t + $urandom_range(0, 45);
            if (t > 255) t = 255;
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         duties = 60'({$urandom(), $urandom()});
      end else begin
         t = $urandom_range(0, 200);
         for (int i = 0; i < CURVE_PTS; i++) begin
            duties[10*i +: 10] = 10'(t);
            t = t + $urandom_range(0, 250);
            if (t > 1023) t = 1023;
         end
      end
      write_reg(CSR_MODE, CSR_DATA_W'(m));
      write_reg(CSR_TARGET_TEMP, CSR_DATA_W'(target8));
      write_reg(CSR_TARGET_SPEED, CSR_DATA_W'(spd));
      write_reg(CSR_MAX_SPEED, CSR_DATA_W'(top));
      write_reg(CSR_TEMP_SPAN, CSR_DATA_W'(span));
      write_reg(CSR_HYST_BAND, CSR_DATA_W'(band));
      write_reg(CSR_CURVE_TEMPS, CSR_DATA_W'(temps));
      write_reg(CSR_CURVE_DUTIES, duties);
   endtask

   // request driver: bursts of transactions separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) begin
            expected_duties.push_back(predict_duty(offered));
            n_sent++;
         end
         if (gap_left > 0 || pending_samples.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_ch.valid <= 1'b0;
         end else begin
            offered = pending_samples.pop_front();
            req_ch.current_temp <= offered.cur;
            req_ch.room_temp <= offered.room;
            req_ch.room_temp_valid <= offered.room_ok;
            req_ch.valid <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, burst_max);
               gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            end
         end
      end
   end

   // response monitor and ready pattern
   always @(posedge clock) begin
      fan_duty_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_duties.size() == 0) begin
               $display("%0t: unexpected transaction, duty %0d percent %0d status %0d",
                        $time, rsp_ch.duty, rsp_ch.duty_percent, rsp_ch.status);
               n_errors++;
            end else begin
               want = expected_duties.pop_front();
               n_checked++;
               if (rsp_ch.duty !== want.duty) begin
                  $display("%0t: duty expected %0d, got %0d", $time, want.duty, rsp_ch.duty);
                  n_errors++;
               end
               if (rsp_ch.duty_percent !== want.pct) begin
                  $display("%0t: duty_percent expected %0d, got %0d",
                           $time, want.pct, rsp_ch.duty_percent);
                  n_errors++;
               end
               if (rsp_ch.status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_ch.status);
                  n_errors++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
         end else begin
            case (stall_style)
               STALL_LIGHT: if ($urandom_range(0, 9) < 3) stall_left = $urandom_range(1, 3);
               STALL_LONG:  if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(10, 50);
               default:     stall_left = 0;
            endcase
         end
         rsp_ch.ready <= (stall_left == 0);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("watchdog expired after %0d cycles, %0d of %0d results seen",
                  cycle_count, n_checked, n_queued);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      temp_sample_type s;
      fdt_mode_type    phase_mode;

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.current_temp = '0;
      req_ch.room_temp = '0;
      req_ch.room_temp_valid = 1'b0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_MODE;
      csr_ch.data = '0;

      cfg_mode = MODE_AUTO;
      cfg_target_temp = 8'sd40;
      cfg_target_speed = 16'd0;
      cfg_max_speed = 16'd3000;
      cfg_temp_span = 12'd320;
      cfg_hyst_band = 8'd5;
      cfg_curve_temps = 48'd77224353472020;
      cfg_curve_duties = '0;
      low_side = 1'b1;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: proportional extremes and flat zero curve
      n_settings++;
      queue_sample(4095, -4096, 1);
      queue_sample(-4096, 4095, 1);
      queue_sample(800, 800, 1);
      queue_sample(0, 0, 0);
      wait_results();

      // curve below first point, on it, between points, above last
      write_reg(CSR_CURVE_DUTIES, {10'd1000, 10'd800, 10'd600, 10'd300, 10'd100, 10'd0});
      n_settings++;
      queue_sample(-4096, 0, 0);
      queue_sample(320, 0, 0);
      queue_sample(500, 0, 0);
      queue_sample(4095, 0, 0);
      wait_results();

      // zero span acts as one
      write_reg(CSR_TEMP_SPAN, CSR_DATA_W'(12'd0));
      n_settings++;
      queue_sample(5, 0, 1);
      queue_sample(1, 0, 1);
      wait_results();

      // hysteresis: drop near the low threshold, rise above the high one
      write_reg(CSR_MODE, CSR_DATA_W'(MODE_TEMP));
      write_reg(CSR_TARGET_TEMP, CSR_DATA_W'(8'd125));
      write_reg(CSR_TEMP_SPAN, CSR_DATA_W'(12'd320));
      write_reg(CSR_HYST_BAND, CSR_DATA_W'(8'd255));
      n_settings++;
      queue_sample(1884, 0, 0);
      queue_sample(2017, 0, 0);
      queue_sample(2000, 0, 1);
      wait_results();

      write_reg(CSR_TARGET_TEMP, CSR_DATA_W'(8'hd8));  // -40
      write_reg(CSR_HYST_BAND, CSR_DATA_W'(8'd0));
      n_settings++;
      queue_sample(-4096, 0, 0);
      queue_sample(4095, 0, 0);
      wait_results();

      // rpm: clamp to max, zero max with zero and nonzero target
      write_reg(CSR_MODE, CSR_DATA_W'(MODE_RPM));
      write_reg(CSR_TARGET_SPEED, CSR_DATA_W'(16'hffff));
      n_settings++;
      queue_sample(0, 0, 0);
      wait_results();
      write_reg(CSR_MAX_SPEED, CSR_DATA_W'(16'd0));
      write_reg(CSR_TARGET_SPEED, CSR_DATA_W'(16'd0));
      n_settings++;
      queue_sample(100, 0, 1);
      wait_results();
      write_reg(CSR_TARGET_SPEED, CSR_DATA_W'(16'd5));
      n_settings++;
      queue_sample(100, 0, 1);
      wait_results();

      write_reg(CSR_MODE, CSR_DATA_W'(MODE_INVALID));
      n_settings++;
      queue_sample(4095, -4096, 1);
      queue_sample(-4096, 4095, 0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_results();
         case (p % 3)
            0: begin
               burst_max = 1;
               gap_max = 0;
            end
            1: begin
               burst_max = 8;
               gap_max = 3;
            end
            default: begin
               burst_max = 4;
               gap_max = 45;
            end
         endcase
         case ((p / 3) % 3)
            0:       stall_style = STALL_NONE;
            1:       stall_style = STALL_LIGHT;
            default: stall_style = STALL_LONG;
         endcase
         case (p % 7)
            0, 1, 2: phase_mode = MODE_AUTO;
            3, 4:    phase_mode = MODE_TEMP;
            5:       phase_mode = MODE_RPM;
            default: phase_mode = MODE_INVALID;
         endcase
         random_settings(phase_mode);
         n_settings++;
         repeat (ITEMS_PER_PHASE) begin
            s = random_sample();
            queue_sample(s.cur, s.room, s.room_ok);
         end
      end

      wait_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d temperature samples sent over %0d register settings, all four modes",
               n_sent, n_settings);
      $display("%0d duties compared, %0d field errors", n_checked, n_errors);
      if (n_errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/fdt_pkg.sv
hw/rtl/fdt_req_if.sv
hw/rtl/fdt_rsp_if.sv
hw/rtl/fdt_csr_if.sv
hw/rtl/fdt_ctrl.sv
hw/rtl/fdt_dp.sv
hw/rtl/fan_duty_from_temperature_core.sv
verif/tb_fan_duty_from_temperature_core.sv
